// ===== hdl/gsr_pkg.sv =====
`timescale 1ns / 1ps

package gsr_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_PASS_MODE = 2'd0;
  localparam logic [1:0] REG_FREQ_STEP = 2'd1;
  localparam logic [1:0] REG_EDGE_FREQ = 2'd2;
  localparam logic [1:0] REG_INV_SIGMA = 2'd3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int COEFF_W = 32;
  localparam int GAIN_W = 32;   // Q1.31, unity is 2^31
  localparam int Z_FRAC_W = 35; // z >= 8 in Q.32 is z >= 2^35

  localparam logic [31:0] INV_SIGMA_RST = 32'h0100_0000;

  localparam int TAYLOR_TERMS = 12;
  localparam int SQUARINGS = 6;

  // Divide by a small loop constant (Taylor term denominators)
  function automatic logic [63:0] div_term(input logic [63:0] t, input int n);
    logic [63:0] q;
    case (n)
      1: q = t;
      2: q = t / 2;
      3: q = t / 3;
      4: q = t / 4;
      5: q = t / 5;
      6: q = t / 6;
      7: q = t / 7;
      8: q = t / 8;
      9: q = t / 9;
      10: q = t / 10;
      11: q = t / 11;
      12: q = t / 12;
      default: q = t;
    endcase
    return q;
  endfunction

  // exp(-0.5*zk^2) in Q1.31 for a Q.16 sample point; elaboration time only
  function automatic logic [31:0] gauss_entry(input logic [63:0] zk);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] e;
    longint sum;
    x = (zk * zk) >> 1;
    y = x >> 7;
    term = 64'd1 << 31;
    sum = longint'(term);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = div_term((term * y) >> 31, n);
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = 64'(sum);
    for (int i = 0; i < SQUARINGS; i++) begin
      e = (e * e) >> 31;
    end
    return e[31:0];
  endfunction

endpackage

// ===== hdl/gsr_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read
module gsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/gaussian_spectral_rolloff_unit.sv =====
`timescale 1ns / 1ps

// Gaussian spectral roll-off. Each word (bin_index, coeff_in) is taken when
// start is high and busy is low, and comes back as coeff_out with a one-cycle
// done strobe at the end of the pipeline. There is no backpressure: the
// receiver must take every result in the cycle it appears. A new word may be
// started every cycle while busy is low, so a full FFT frame streams through
// at one bin per clock. The pipeline stages are: bin frequency multiply,
// pass/edge compare, distance times inv_sigma multiply, gain RAM address and
// registered read, coefficient times gain multiply, then round and saturate.
// After reset busy stays high while the gain RAM is loaded one entry per
// cycle; configuration writes are taken during that time.
// Registers are written through cfg_we/cfg_index/cfg_data and should only be
// changed while no word is in flight.
module gaussian_spectral_rolloff_unit #(
  parameter int BIN_INDEX_BITS = 13,
  parameter int GAUSS_TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [BIN_INDEX_BITS-1:0]         bin_index,
  input  logic signed [gsr_pkg::COEFF_W-1:0] coeff_in,
  output logic                              done,
  output logic signed [gsr_pkg::COEFF_W-1:0] coeff_out,
  input  logic                              cfg_we,
  input  logic [gsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gsr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int FW = BIN_INDEX_BITS + 32;           // bin frequency, Q.8
  localparam int KW = $clog2(GAUSS_TABLE_DEPTH);     // table index
  localparam int DW = $clog2(GAUSS_TABLE_DEPTH) + 1; // table depth itself
  localparam int ZW = gsr_pkg::Z_FRAC_W;
  localparam int CW = gsr_pkg::COEFF_W;
  localparam int GW = gsr_pkg::GAIN_W;
  localparam logic [ZW+DW-1:0] DEPTH_C = (ZW+DW)'(GAUSS_TABLE_DEPTH);
  localparam logic [KW-1:0] FILL_LAST = KW'(GAUSS_TABLE_DEPTH - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        pass_mode;
  logic [31:0] freq_step;
  logic [31:0] edge_freq;
  logic [31:0] inv_sigma;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_mode <= 1'b0;
      freq_step <= '0;
      edge_freq <= '0;
      inv_sigma <= gsr_pkg::INV_SIGMA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gsr_pkg::REG_PASS_MODE: pass_mode <= cfg_data[0];
        gsr_pkg::REG_FREQ_STEP: freq_step <= cfg_data;
        gsr_pkg::REG_EDGE_FREQ: edge_freq <= cfg_data;
        gsr_pkg::REG_INV_SIGMA: inv_sigma <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Gain table: constants folded at elaboration, copied into RAM after reset
  // ---------------------------------------------------------------------------
  logic [GW-1:0] gain_const [GAUSS_TABLE_DEPTH];

  for (genvar gk = 0; gk < GAUSS_TABLE_DEPTH; gk++) begin : g_gain
    // sample point zk = k * 8 / DEPTH in Q.16
    localparam logic [63:0] ZK = (64'(gk) << 19) / GAUSS_TABLE_DEPTH;
    assign gain_const[gk] = gsr_pkg::gauss_entry(ZK);
  end

  logic          filling;
  logic [KW-1:0] fill_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      filling  <= 1'b1;
      fill_cnt <= '0;
    end else if (filling) begin
      fill_cnt <= fill_cnt + 1'b1;
      if (fill_cnt == FILL_LAST) begin
        filling <= 1'b0;
      end
    end
  end

  assign busy = filling;

  logic          accept;
  assign accept = start && !filling;

  // ---------------------------------------------------------------------------
  // Stage 1: bin frequency f = index * freq_step
  // ---------------------------------------------------------------------------
  logic                 v1;
  logic [FW-1:0]        f1;
  logic signed [CW-1:0] coeff1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    f1     <= FW'(bin_index) * FW'(freq_step);
    coeff1 <= coeff_in;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: pass decision and distance from the edge
  // ---------------------------------------------------------------------------
  logic [FW-1:0] mu_ext;
  logic          pass_next;
  logic [FW-1:0] d_next;

  assign mu_ext = FW'(edge_freq);

  always_comb begin
    if (!pass_mode) begin
      pass_next = f1 < mu_ext;
      d_next    = f1 - mu_ext;
    end else begin
      pass_next = f1 > mu_ext;
      d_next    = mu_ext - f1;
    end
  end

  logic                 v2;
  logic                 pass2;
  logic [FW-1:0]        d2;
  logic signed [CW-1:0] coeff2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    pass2  <= pass_next;
    d2     <= d_next;
    coeff2 <= coeff1;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: z = d * inv_sigma (Q.32); upper distance bits force the far tail
  // ---------------------------------------------------------------------------
  logic                 v3;
  logic                 pass3;
  logic                 far3;
  logic [63:0]          z3;
  logic signed [CW-1:0] coeff3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    pass3  <= pass2;
    far3   <= (d2[FW-1:32] != '0) && (inv_sigma != '0);
    z3     <= 64'(d2[31:0]) * 64'(inv_sigma);
    coeff3 <= coeff2;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: table index k = z * DEPTH / 8, registered RAM read
  // ---------------------------------------------------------------------------
  logic [ZW+DW-1:0] kprod;
  logic [KW-1:0]    k_addr;

  assign kprod  = {{DW{1'b0}}, z3[ZW-1:0]} * DEPTH_C;
  assign k_addr = kprod[ZW+KW-1:ZW];

  logic [GW-1:0] gain_rd;

  gsr_ram #(
    .WIDTH (GW),
    .DEPTH (GAUSS_TABLE_DEPTH)
  ) u_gain_ram (
    .clk   (clk),
    .we    (filling),
    .waddr (fill_cnt),
    .wdata (gain_const[fill_cnt]),
    .raddr (k_addr),
    .rdata (gain_rd)
  );

  logic                 v4;
  logic                 pass4;
  logic                 far4;
  logic signed [CW-1:0] coeff4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    pass4  <= pass3;
    far4   <= far3 || (z3[63:ZW] != '0);
    coeff4 <= coeff3;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: product coeff * gain (Q.59)
  // ---------------------------------------------------------------------------
  logic [GW-1:0]       gain;
  logic signed [GW:0]  gain_s;
  logic signed [63:0]  prod_next;

  assign gain      = far4 ? '0 : gain_rd;
  assign gain_s    = signed'({1'b0, gain});
  assign prod_next = 64'(coeff4 * gain_s);

  logic                 v5;
  logic                 pass5;
  logic signed [63:0]   prod5;
  logic signed [CW-1:0] coeff5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    pass5  <= pass4;
    prod5  <= prod_next;
    coeff5 <= coeff4;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: round to Q4.28, saturate, output register
  // ---------------------------------------------------------------------------
  logic signed [64:0]   rsum;
  logic signed [33:0]   rq;
  logic signed [CW-1:0] sat;

  assign rsum = {prod5[63], prod5} + (65'sd1 <<< 30);
  assign rq   = rsum[64:31];

  always_comb begin
    if (rq[33:31] == 3'b000 || rq[33:31] == 3'b111) begin
      sat = rq[CW-1:0];
    end else if (rq[33]) begin
      sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v5;
    end
    coeff_out <= pass5 ? coeff5 : sat;
  end

endmodule
